// ----- sv/rbvp_pkg.sv -----
package rbvp_pkg;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SRC_NORM = 3'd1,
    ST_TGT_NORM = 3'd2,
    ST_SRC_ZERO = 3'd3,
    ST_TGT_ZERO = 3'd4
  } rbvp_status_t;

  typedef enum logic {
    CFG_UNIT_TOL = 1'b0,
    CFG_ZERO_THR = 1'b1
  } rbvp_cfg_idx_t;

  typedef struct packed {
    logic s1;
    logic s2;
  } rbvp_stage_en_t;

  localparam logic [31:0] UNIT_TOL_RST = 32'd26844;
  localparam logic [31:0] ZERO_THR_RST = 32'd0;

endpackage

// ----- sv/rbvp_cross.sv -----
module rbvp_cross
  import rbvp_pkg::*;
#(
  parameter int CW = 16,
  parameter int FB = 14
) (
  input  logic                 clk,
  input  rbvp_stage_en_t       en,
  input  logic signed [CW-1:0] n [3],
  input  logic signed [CW-1:0] o [3],
  output logic signed [CW-1:0] r [3]
);

  localparam int XW = ((2*CW+1 > FB+1) ? 2*CW+1 : FB+1) + 1;
  localparam logic signed [XW-1:0] SMAX = {{(XW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [XW-1:0] SMIN = {{(XW-CW+1){1'b1}}, {(CW-1){1'b0}}};
  localparam logic signed [XW-1:0] RND  = {{(XW-1){1'b0}}, 1'b1} << (FB-1);

  // stage 1: raw products of n x o
  logic signed [2*CW-1:0] p_r   [6];
  logic signed [2*CW-1:0] p_nxt [6];
  logic signed [CW-1:0]   r_nxt [3];

  always_comb begin
    p_nxt[0] = n[1] * o[2];
    p_nxt[1] = n[2] * o[1];
    p_nxt[2] = n[2] * o[0];
    p_nxt[3] = n[0] * o[2];
    p_nxt[4] = n[0] * o[1];
    p_nxt[5] = n[1] * o[0];
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      p_r <= p_nxt;
    end
  end

  // stage 2: difference, round half up, saturate
  always_comb begin
    logic signed [XW-1:0] d;
    logic signed [XW-1:0] q;
    for (int k = 0; k < 3; k++) begin
      d = XW'(p_r[2*k]) - XW'(p_r[2*k+1]) + RND;
      q = d >>> FB;
      if (q > SMAX) begin
        r_nxt[k] = SMAX[CW-1:0];
      end else if (q < SMIN) begin
        r_nxt[k] = SMIN[CW-1:0];
      end else begin
        r_nxt[k] = q[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      r <= r_nxt;
    end
  end

endmodule

// ----- sv/rosy4_best_vector_pair_core.sv -----
// Throughput: one request per cycle; a stalled output holds the pipe, bubbles fill.
// Pipeline: products, sums and rotation, checks and dot products, dot sums, pick.
// Reset: synchronous active-low rst_n clears all stage valid bits and loads
// unit_tolerance = 26844 and zero_threshold = 0.
module rosy4_best_vector_pair_core
  import rbvp_pkg::*;
#(
  parameter int FRAC_BITS  = 14,
  parameter int COMP_WIDTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // target_vec_x/y/z, target_norm_x/y/z, source_vec_x/y/z, source_norm_x/y/z
  input  logic [((12*COMP_WIDTH+7)/8)*8-1:0]    in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // best_target_x/y/z, best_source_x/y/z, target_rotation, source_rotation, status
  output logic [((6*COMP_WIDTH+6+7)/8)*8-1:0]   out_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic                                  cfg_index,
  input  logic [31:0]                           cfg_data
);

  localparam int CW   = COMP_WIDTH;
  localparam int FB   = FRAC_BITS;
  localparam int OW   = ((6*CW+6+7)/8)*8;
  localparam int SQW  = ((2*CW > 2*FB+1) ? 2*CW : 2*FB+1) + 1;
  localparam int CMPW = (SQW > 32) ? SQW : 32;
  localparam int DW   = 2*CW + 2;
  localparam int MW   = 2*CW + 1;
  localparam logic [SQW-1:0] ONE = {{(SQW-1){1'b0}}, 1'b1} << (2*FB);
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  // configuration
  logic [31:0] unit_tol_r, zero_thr_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_tol_r <= UNIT_TOL_RST;
      zero_thr_r <= ZERO_THR_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_UNIT_TOL: unit_tol_r <= cfg_data;
        CFG_ZERO_THR: zero_thr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage enables and valids
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;
  rbvp_stage_en_t cross_en;

  assign en5 = !v5_r || out_tready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_tready  = en1;
  assign out_tvalid = v5_r;
  assign cross_en   = '{s1: en1, s2: en2};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  // input unpack: group 0 source normal, 1 target normal, 2 source, 3 target
  logic signed [CW-1:0] tv [3], tn [3], sv [3], sn [3];
  logic signed [CW-1:0] grp [4][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tv[k] = in_tdata[k*CW +: CW];
      tn[k] = in_tdata[(3+k)*CW +: CW];
      sv[k] = in_tdata[(6+k)*CW +: CW];
      sn[k] = in_tdata[(9+k)*CW +: CW];
      grp[0][k] = sn[k];
      grp[1][k] = tn[k];
      grp[2][k] = sv[k];
      grp[3][k] = tv[k];
    end
  end

  // stage 1: squares
  logic signed [2*CW-1:0] sq_r [4][3];
  logic signed [2*CW-1:0] sq_nxt [4][3];
  logic signed [CW-1:0]   a0_1_r [3], b0_1_r [3];

  always_comb begin
    for (int g = 0; g < 4; g++) begin
      for (int k = 0; k < 3; k++) begin
        sq_nxt[g][k] = grp[g][k] * grp[g][k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      sq_r   <= sq_nxt;
      a0_1_r <= tv;
      b0_1_r <= sv;
    end
  end

  // rotations, registered at stage 2
  logic signed [CW-1:0] a1_2 [3], b1_2 [3];

  rbvp_cross #(.CW(CW), .FB(FB)) u_cross_tgt (
    .clk (clk),
    .en  (cross_en),
    .n   (tn),
    .o   (tv),
    .r   (a1_2)
  );

  rbvp_cross #(.CW(CW), .FB(FB)) u_cross_src (
    .clk (clk),
    .en  (cross_en),
    .n   (sn),
    .o   (sv),
    .r   (b1_2)
  );

  // stage 2: squared norms
  logic [SQW-1:0]       sqn_r [4];
  logic [SQW-1:0]       sqn_nxt [4];
  logic signed [CW-1:0] a0_2_r [3], b0_2_r [3];

  always_comb begin
    for (int g = 0; g < 4; g++) begin
      sqn_nxt[g] = SQW'(sq_r[g][0][2*CW-2:0]) + SQW'(sq_r[g][1][2*CW-2:0])
                 + SQW'(sq_r[g][2][2*CW-2:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      sqn_r  <= sqn_nxt;
      a0_2_r <= a0_1_r;
      b0_2_r <= b0_1_r;
    end
  end

  // stage 3: checks and dot-product terms; pair p = 2*i + j pairs a[i] with b[j]
  rbvp_status_t         st_3_r, st_3_nxt;
  logic signed [2*CW-1:0] dp_r [4][3];
  logic signed [2*CW-1:0] dp_nxt [4][3];
  logic signed [CW-1:0] a0_3_r [3], a1_3_r [3], b0_3_r [3], b1_3_r [3];
  logic signed [CW-1:0] av2 [2][3], bv2 [2][3];
  logic                 unit_ok [2];
  logic                 nz [2];

  always_comb begin
    logic [SQW-1:0] d;
    for (int g = 0; g < 2; g++) begin
      d = (sqn_r[g] >= ONE) ? sqn_r[g] - ONE : ONE - sqn_r[g];
      unit_ok[g] = CMPW'(d) <= CMPW'(unit_tol_r);
      nz[g]      = CMPW'(sqn_r[g+2]) > CMPW'(zero_thr_r);
    end
    if (!unit_ok[0]) begin
      st_3_nxt = ST_SRC_NORM;
    end else if (!unit_ok[1]) begin
      st_3_nxt = ST_TGT_NORM;
    end else if (!nz[0]) begin
      st_3_nxt = ST_SRC_ZERO;
    end else if (!nz[1]) begin
      st_3_nxt = ST_TGT_ZERO;
    end else begin
      st_3_nxt = ST_OK;
    end
  end

  always_comb begin
    av2[0] = a0_2_r;
    av2[1] = a1_2;
    bv2[0] = b0_2_r;
    bv2[1] = b1_2;
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        for (int k = 0; k < 3; k++) begin
          dp_nxt[2*i+j][k] = av2[i][k] * bv2[j][k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      st_3_r <= st_3_nxt;
      dp_r   <= dp_nxt;
      a0_3_r <= a0_2_r;
      a1_3_r <= a1_2;
      b0_3_r <= b0_2_r;
      b1_3_r <= b1_2;
    end
  end

  // stage 4: dot sums as magnitude and sign
  rbvp_status_t         st_4_r;
  logic [MW-1:0]        mag_4_r [4];
  logic [MW-1:0]        mag_nxt [4];
  logic                 neg_4_r [4];
  logic                 neg_nxt [4];
  logic signed [CW-1:0] a0_4_r [3], a1_4_r [3], b0_4_r [3], b1_4_r [3];

  always_comb begin
    logic signed [DW-1:0] s;
    for (int p = 0; p < 4; p++) begin
      s = DW'(dp_r[p][0]) + DW'(dp_r[p][1]) + DW'(dp_r[p][2]);
      neg_nxt[p] = s[DW-1];
      mag_nxt[p] = s[DW-1] ? MW'(-s) : MW'(s);
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      st_4_r  <= st_3_r;
      mag_4_r <= mag_nxt;
      neg_4_r <= neg_nxt;
      a0_4_r  <= a0_3_r;
      a1_4_r  <= a1_3_r;
      b0_4_r  <= b0_3_r;
      b1_4_r  <= b1_3_r;
    end
  end

  // stage 5: first strict maximum, sign fix, zero payload on error, output register
  logic signed [CW-1:0] bt_r [3], bs_r [3];
  logic signed [CW-1:0] bt_nxt [3], bs_nxt [3];
  logic                 trot_r, trot_nxt;
  logic [1:0]           srot_r, srot_nxt;
  rbvp_status_t         st_r;

  always_comb begin
    logic [1:0]           sel;
    logic [MW-1:0]        best;
    logic                 ng;
    logic signed [CW-1:0] b;
    sel  = 2'd0;
    best = mag_4_r[0];
    for (int p = 1; p < 4; p++) begin
      if (mag_4_r[p] > best) begin
        best = mag_4_r[p];
        sel  = 2'(p);
      end
    end
    ng = neg_4_r[sel];
    for (int k = 0; k < 3; k++) begin
      bt_nxt[k] = sel[1] ? a1_4_r[k] : a0_4_r[k];
      b = sel[0] ? b1_4_r[k] : b0_4_r[k];
      if (ng) begin
        b = (b == CMIN) ? CMAX : -b;
      end
      bs_nxt[k] = b;
    end
    trot_nxt = sel[1];
    srot_nxt = {ng, sel[0]};
    if (st_4_r != ST_OK) begin
      for (int k = 0; k < 3; k++) begin
        bt_nxt[k] = '0;
        bs_nxt[k] = '0;
      end
      trot_nxt = 1'b0;
      srot_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      bt_r   <= bt_nxt;
      bs_r   <= bs_nxt;
      trot_r <= trot_nxt;
      srot_r <= srot_nxt;
      st_r   <= st_4_r;
    end
  end

  assign out_tdata = OW'({st_r, srot_r, trot_r, bs_r[2], bs_r[1], bs_r[0],
                          bt_r[2], bt_r[1], bt_r[0]});

`ifndef ASSERT_OFF
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && st_r != ST_OK) |->
      (bt_r[0] == '0 && bt_r[1] == '0 && bt_r[2] == '0 && bs_r[0] == '0 &&
       bs_r[1] == '0 && bs_r[2] == '0 && !trot_r && srot_r == 2'd0))
    else $error("error result carries nonzero payload");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (v1_r && v2_r && v3_r && v4_r && v5_r && !out_tready))
    else $error("input stalled with a bubble in the pipeline");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (st_r == ST_OK || st_r == ST_SRC_NORM || st_r == ST_TGT_NORM ||
                    st_r == ST_SRC_ZERO || st_r == ST_TGT_ZERO))
    else $error("status out of range");

  a_reset_empty: assert property (@(posedge clk)
    (rst_n && !$past(rst_n)) |-> (!v1_r && !v2_r && !v3_r && !v4_r && !out_tvalid))
    else $error("pipeline not empty after reset");
`endif

endmodule
